>>> hdl/sal_pkg.sv
// ----------------------------------------------------------------------------
// sal_pkg: shared types and constants for the security access lockout block
// Payload words, state record, kind/status/register codes and fixed sizes.
// ----------------------------------------------------------------------------
package sal_pkg;

    // Fixed sizes of the seed/key exchange
    localparam int SeedBytes = 8;
    localparam int KeyBytes  = 4;

    localparam logic [63:0] SeedMask = (SeedBytes >= 8) ? {64{1'b1}} :
        ((64'd1 << (8 * SeedBytes)) - 64'd1);
    localparam logic [3:0]  SeedLen        = 4'(SeedBytes);
    localparam logic [7:0]  KeyLen         = 8'(KeyBytes);
    localparam logic [7:0]  SeedLenBytes   = 8'(SeedBytes);
    localparam logic [7:0]  OddMask        = 8'h01;
    localparam logic [31:0] LockoutDefault = 32'd10000;
    localparam logic [7:0]  AttemptLimitRst = 8'd3;
    localparam logic [31:0] LockoutTimeRst  = 32'd10000;

    // Item kinds
    typedef enum logic [2:0] {
        KIND_REQ_SEED = 3'd0,
        KIND_SEND_KEY = 3'd1,
        KIND_TICK     = 3'd2,
        KIND_SESS_RST = 3'd3,
        KIND_RESTORE  = 3'd4
    } sal_kind_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_PARAM   = 3'd1,
        ST_EXCEEDED    = 3'd2,
        ST_SEED_UNAVL  = 3'd3,
        ST_BUF_SMALL   = 3'd4,
        ST_OUT_RANGE   = 3'd5,
        ST_BAD_KEY     = 3'd6
    } sal_status_t;

    // Configuration register indexes
    localparam logic [7:0] CFG_ATTEMPT_LIMIT = 8'd0;
    localparam logic [7:0] CFG_LOCKOUT_TIME  = 8'd1;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  level;
        logic [63:0] seed_value;
        logic        seed_valid;
        logic [7:0]  buffer_length;
        logic [7:0]  key_length;
        logic        key_ok;
        logic [7:0]  restore_attempts;
        logic [31:0] restore_lockout_ms;
    } sal_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] seed_out;
        logic [3:0]  seed_length;
        logic [7:0]  current_level;
        logic        level_active;
        logic        lockout_flag;
        logic [7:0]  attempts_now;
        logic [31:0] lockout_left_ms;
        logic        persist;
    } sal_out_t;

    // Session and lockout state carried between the step logic and the top
    typedef struct packed {
        logic [7:0]  active_lvl;
        logic [7:0]  pending_lvl;
        logic        seed_armed;
        logic [7:0]  fail_count;
        logic        locked;
        logic [31:0] lock_timer;
    } sal_state_t;

    // Configuration register values
    typedef struct packed {
        logic [7:0]  attempt_limit;
        logic [31:0] lockout_time_ms;
    } sal_cfg_t;

endpackage

>>> hdl/sal_step.sv
// ----------------------------------------------------------------------------
// sal_step: one-item step of the seed/key controller
// Computes the next session/lockout state and the result word for one item.
// ----------------------------------------------------------------------------
module sal_step (
    input  sal_pkg::sal_state_t cur_state,
    input  sal_pkg::sal_cfg_t   cfg,
    input  sal_pkg::sal_in_t    item,
    output sal_pkg::sal_state_t nxt_state,
    output sal_pkg::sal_out_t   result
);
    import sal_pkg::*;

    logic [63:0] seed_m;
    logic [7:0]  expect_lvl;
    logic [7:0]  fail_inc;
    logic        key_good;
    logic [2:0]  status;
    logic [63:0] seed_out;
    logic [3:0]  seed_nbytes;
    logic        persist;

    assign seed_m     = item.seed_value & SeedMask;
    assign expect_lvl = (item.level != 8'd0) ? (item.level - 8'd1) : 8'd0;
    assign fail_inc   = (cur_state.fail_count == 8'hFF) ? cur_state.fail_count
                                                       : (cur_state.fail_count + 8'd1);
    assign key_good   = (item.key_length == KeyLen) && item.key_ok;

    // Decode the item kind and apply its rule
    always_comb begin
        nxt_state   = cur_state;
        status      = ST_OK;
        seed_out    = '0;
        seed_nbytes = '0;
        persist     = 1'b0;
        unique case (item.kind)
            KIND_REQ_SEED: begin
                if ((item.level & OddMask) == 8'd0) begin
                    status = ST_BAD_PARAM;
                end else if (cur_state.locked) begin
                    status = ST_EXCEEDED;
                end else if (item.buffer_length < SeedLenBytes) begin
                    status = ST_BUF_SMALL;
                end else if (cur_state.active_lvl == item.level) begin
                    // level already open: zero seed, drop any pending request
                    seed_nbytes           = SeedLen;
                    nxt_state.seed_armed  = 1'b0;
                    nxt_state.pending_lvl = '0;
                end else if (!item.seed_valid || seed_m == 64'd0) begin
                    status                = ST_SEED_UNAVL;
                    nxt_state.seed_armed  = 1'b0;
                    nxt_state.pending_lvl = '0;
                end else begin
                    seed_out              = seed_m;
                    seed_nbytes           = SeedLen;
                    nxt_state.pending_lvl = item.level;
                    nxt_state.seed_armed  = 1'b1;
                end
            end
            KIND_SEND_KEY: begin
                if (cur_state.locked) begin
                    status = ST_EXCEEDED;
                end else if (!cur_state.seed_armed) begin
                    status = ST_SEED_UNAVL;
                end else if (item.key_length == 8'd0) begin
                    status = ST_BAD_PARAM;
                end else if (expect_lvl != cur_state.pending_lvl) begin
                    status = ST_OUT_RANGE;
                end else begin
                    nxt_state.seed_armed = 1'b0;
                    persist              = 1'b1;
                    if (!key_good) begin
                        // count the failure, lock out once the limit is reached
                        if (fail_inc >= cfg.attempt_limit) begin
                            nxt_state.locked     = 1'b1;
                            nxt_state.lock_timer = (cfg.lockout_time_ms != 32'd0) ?
                                cfg.lockout_time_ms : LockoutDefault;
                            nxt_state.fail_count = '0;
                            status               = ST_EXCEEDED;
                        end else begin
                            nxt_state.fail_count = fail_inc;
                            status               = ST_BAD_KEY;
                        end
                    end else begin
                        nxt_state.active_lvl  = cur_state.pending_lvl;
                        nxt_state.fail_count  = '0;
                        nxt_state.pending_lvl = '0;
                    end
                end
            end
            KIND_TICK: begin
                // count the lockout down, release at zero
                if (cur_state.locked && cur_state.lock_timer != 32'd0) begin
                    nxt_state.lock_timer = cur_state.lock_timer - 32'd1;
                    if (cur_state.lock_timer == 32'd1) begin
                        nxt_state.locked = 1'b0;
                    end
                end
            end
            KIND_SESS_RST: begin
                nxt_state.active_lvl  = '0;
                nxt_state.seed_armed  = 1'b0;
                nxt_state.pending_lvl = '0;
            end
            KIND_RESTORE: begin
                nxt_state.active_lvl  = '0;
                nxt_state.seed_armed  = 1'b0;
                nxt_state.pending_lvl = '0;
                nxt_state.fail_count  = (item.restore_attempts <= cfg.attempt_limit) ?
                    item.restore_attempts : cfg.attempt_limit;
                nxt_state.locked      = (item.restore_lockout_ms != 32'd0);
                nxt_state.lock_timer  = item.restore_lockout_ms;
            end
            default: begin
                // unused kinds leave everything as is
            end
        endcase
    end

    // Build the result word from the updated state
    always_comb begin
        result.status          = status;
        result.seed_out        = seed_out;
        result.seed_length     = seed_nbytes;
        result.current_level   = nxt_state.active_lvl;
        result.level_active    = (item.level == nxt_state.active_lvl);
        result.lockout_flag    = nxt_state.locked;
        result.attempts_now    = nxt_state.fail_count;
        result.lockout_left_ms = nxt_state.lock_timer;
        result.persist         = persist;
    end

endmodule

>>> hdl/security_access_lockout_fsm_top.sv
// A word accepted on the input passes the input register, then the result register, before it shows on m_data.
// Throughput: one word per cycle while m_ready is high; input register and result register each hold one word.
// The step logic between them is a single pass over the session/lockout registers.
// Reset (aresetn low, synchronous): both registers empty, state cleared,
// attempt_limit = 3, lockout_time_ms = 10000. Configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
// security_access_lockout_fsm_top: seed/key security access controller
// Input register, single-pass step logic with state, and result register.
// ----------------------------------------------------------------------------
module security_access_lockout_fsm_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sal_pkg::sal_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sal_pkg::sal_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import sal_pkg::*;

    logic       in_valid_reg;
    sal_in_t    in_data_reg;
    logic       out_valid_reg;
    sal_out_t   out_data_reg;
    sal_state_t state_reg;
    sal_state_t state_next;
    sal_cfg_t   cfg_reg;
    sal_out_t   result_next;
    logic       advance;

    // Move the held word into the result register when that slot frees up
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;
    assign cfg_ready = 1'b1;

    sal_step u_step (
        .cur_state (state_reg),
        .cfg       (cfg_reg),
        .item      (in_data_reg),
        .nxt_state (state_next),
        .result    (result_next)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Result register and state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (advance) begin
            out_data_reg <= result_next;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.attempt_limit   <= AttemptLimitRst;
            cfg_reg.lockout_time_ms <= LockoutTimeRst;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ATTEMPT_LIMIT: cfg_reg.attempt_limit   <= cfg_data[7:0];
                CFG_LOCKOUT_TIME:  cfg_reg.lockout_time_ms <= cfg_data;
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

endmodule

>>> hdl/sal_checker.sv
// ----------------------------------------------------------------------------
// sal_checker: port-level checks on the security access controller
// Watches the result channel and bound to the top level.
// ----------------------------------------------------------------------------
module sal_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input sal_pkg::sal_out_t m_data
);
    import sal_pkg::*;

    // A stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // Reset empties the result register
    a_rst_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Lock flag and remaining time agree
    a_lock_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.lockout_flag == (m_data.lockout_left_ms != 32'd0)))
        else $error("lockout flag and timer disagree");

    // A seed is only returned with a seed length
    a_seed_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.seed_length == 4'd0) |-> (m_data.seed_out == 64'd0))
        else $error("seed returned without length");

    // Persist only follows a judged key
    a_persist: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.persist |->
            (m_data.status == ST_OK) || (m_data.status == ST_EXCEEDED) ||
            (m_data.status == ST_BAD_KEY))
        else $error("persist strobe on wrong status");

endmodule

bind security_access_lockout_fsm_top sal_checker u_sal_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
